[sv/tdp_pkg.sv]
// Package for the trial division prime test: value width, counter widths
// and the command and status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

    // Width of the candidate field on the input channel.
    localparam int CANDIDATE_WIDTH = 32;

    // Number of low candidate bits that are tested; the top kept bit is the sign.
    localparam int VALUE_WIDTH = 32;

    // Step counter of the bit-serial divider.
    localparam int DIV_CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(VALUE_WIDTH - 1);

    // First odd trial divisor and the stride between divisors.
    localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(3);
    localparam logic [VALUE_WIDTH-1:0] DIVISOR_STEP  = VALUE_WIDTH'(2);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the candidate and reset the divisor
        logic start;  // begin a division of the value by the divisor
        logic step;   // one restoring division step
        logic next;   // advance to the next odd divisor
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic value_neg;
        logic value_le_one;
        logic value_two;
        logic value_even;
        logic div_last;    // the current step is the last of the division
        logic bound_over;  // divisor exceeds the quotient: no more divisors
        logic rem_zero;    // remainder is zero: a factor is found
    } t_dp_stat;

endpackage

`default_nettype wire

[sv/tdp_in_if.sv]
// Input channel of the trial division prime test: valid, ready, candidate.
// Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tdp_in_if import tdp_pkg::*;;
    logic                              valid;
    logic                              ready;
    logic signed [CANDIDATE_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

`default_nettype wire

[sv/tdp_out_if.sv]
// Output channel of the trial division prime test: valid, ready, is_prime.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tdp_out_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

[sv/tdp_dp.sv]
// Datapath of the trial division prime test: value and divisor registers and
// a bit-serial restoring divider that yields quotient and remainder.
// Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdp_dp import tdp_pkg::*; (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire t_dp_cmd                           i_cmd,
    input  wire logic signed [CANDIDATE_WIDTH-1:0] i_candidate,
    output t_dp_stat                               o_stat
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] r_divisor;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [DIV_CNT_W-1:0]   r_cnt;

    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH-1:0] rem_diff;
    logic                   rem_ge;

    // One restoring step: bring down the next dividend bit and try to subtract.
    // When the subtraction succeeds the difference is below the divisor, so the
    // low VALUE_WIDTH bits hold all of it.
    assign rem_shift = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign rem_diff  = rem_shift[VALUE_WIDTH-1:0] - r_divisor;
    assign rem_ge    = rem_shift >= {1'b0, r_divisor};

    // Value and divisor registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value   <= VALUE_WIDTH'($unsigned(i_candidate));
            r_divisor <= FIRST_DIVISOR;
        end else if (i_cmd.next) begin
            r_divisor <= r_divisor + DIVISOR_STEP;
        end
    end

    // Divider: the quotient register shifts out dividend bits and in quotient bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= '0;
            r_quo <= r_value;
        end else if (i_cmd.step) begin
            r_rem <= rem_ge ? rem_diff : rem_shift[VALUE_WIDTH-1:0];
            r_quo <= {r_quo[VALUE_WIDTH-2:0], rem_ge};
        end
    end

    // Status towards the controller.
    always_comb begin
        o_stat.value_neg    = r_value[VALUE_WIDTH-1];
        o_stat.value_le_one = r_value <= VALUE_WIDTH'(1);
        o_stat.value_two    = r_value == VALUE_WIDTH'(2);
        o_stat.value_even   = !r_value[0];
        o_stat.div_last     = r_cnt == DIV_LAST;
        o_stat.bound_over   = r_divisor > r_quo;
        o_stat.rem_zero     = r_rem == '0;
    end

endmodule

`default_nettype wire

[sv/tdp_ctrl.sv]
// Controller of the trial division prime test: sequences the special cases,
// the divisions and the result transfer, and holds the output register.
// Depends on tdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdp_ctrl import tdp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output logic          o_out_is_prime,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIVIDE,
        S_EVAL,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_result, n_result;
    logic   r_out_valid, n_out_valid;
    logic   r_out_is_prime, n_out_is_prime;

    assign o_in_ready     = r_state == S_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_out_is_prime = r_out_is_prime;

    // Next state, commands and the output register.
    always_comb begin
        n_state        = r_state;
        n_result       = r_result;
        n_out_valid    = r_out_valid;
        n_out_is_prime = r_out_is_prime;
        o_cmd          = '0;

        // A waiting result leaves on a transfer.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.value_neg || i_stat.value_le_one) begin
                    n_result = 1'b0;
                    n_state  = S_RESULT;
                end else if (i_stat.value_two) begin
                    n_result = 1'b1;
                    n_state  = S_RESULT;
                end else if (i_stat.value_even) begin
                    n_result = 1'b0;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                o_cmd.step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                // The bound is tested before the remainder, as in the loop condition.
                priority if (i_stat.bound_over) begin
                    n_result = 1'b1;
                    n_state  = S_RESULT;
                end else if (i_stat.rem_zero) begin
                    n_result = 1'b0;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.next  = 1'b1;
                    o_cmd.start = 1'b1;
                    n_state     = S_DIVIDE;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid    = 1'b1;
                    n_out_is_prime = r_result;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_result       <= n_result;
        r_out_is_prime <= n_out_is_prime;
    end

endmodule

`default_nettype wire

[sv/trial_division_prime_test.sv]
// Trial division prime test: one signed candidate in, one is_prime flag out.
// A candidate that is negative, zero, one or even (other than two) is answered
// without any division. An odd candidate is divided by 3, 5, 7 and so on until
// the divisor exceeds the quotient or a remainder of zero is found; each trial
// runs through the bit-serial restoring divider. Items are handled one at a
// time; a result waits in an output register, so the next candidate is taken
// while the previous result has not yet been transferred.
// Depends on tdp_pkg, tdp_in_if, tdp_out_if, tdp_dp and tdp_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test import tdp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tdp_in_if.sink     i_in,
    tdp_out_if.source  o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;
    logic     out_is_prime;

    assign i_in.ready     = in_ready;
    assign o_out.valid    = out_valid;
    assign o_out.is_prime = out_is_prime;

    // Sequencing and output register.
    tdp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (in_ready),
        .o_out_valid    (out_valid),
        .i_out_ready    (o_out.ready),
        .o_out_is_prime (out_is_prime),
        .o_cmd          (cmd),
        .i_stat         (stat)
    );

    // Value, divisor and divider.
    tdp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_candidate (i_in.candidate),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire

[sim/tb_trial_division_prime_test.sv]
// Testbench for trial_division_prime_test: directed candidates, then random ones,
// each answer checked against a trial-division predictor held in the bench.
// Depends on tdp_pkg, tdp_in_if, tdp_out_if and the block itself.
`timescale 1ns / 1ps

module tb_trial_division_prime_test;
    import tdp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int          RANDOM_ITEMS = 100;
    localparam int          HOLD_CYCLES  = 4000;

    // One directed row: the candidate and, where it is obvious, the answer.
    typedef struct {
        logic [CANDIDATE_WIDTH-1:0] candidate;
        bit                         known;
        bit                         flag;
    } t_tdp_row;

    // One answer still owed by the block.
    typedef struct {
        logic [CANDIDATE_WIDTH-1:0] candidate;
        bit                         flag;
    } t_owed_answer;

    localparam int N_DIRECTED = 22;

    t_tdp_row directed_rows [N_DIRECTED] = '{
        '{32'd0,           1'b1, 1'b0},
        '{32'd1,           1'b1, 1'b0},
        '{32'd2,           1'b1, 1'b1},
        '{32'd3,           1'b0, 1'b0},
        '{32'd4,           1'b0, 1'b0},
        '{32'hFFFF_FFFF,   1'b1, 1'b0},
        '{32'h8000_0000,   1'b1, 1'b0},
        '{32'h7FFF_FFFF,   1'b1, 1'b1},
        '{32'd9,           1'b0, 1'b0},
        '{32'd25,          1'b0, 1'b0},
        '{32'd49,          1'b0, 1'b0},
        '{32'd15,          1'b0, 1'b0},
        '{32'd17,          1'b0, 1'b0},
        '{32'd97,          1'b0, 1'b0},
        '{32'd121,         1'b0, 1'b0},
        '{32'd65521,       1'b0, 1'b0},
        '{32'h7FFF_FFFE,   1'b1, 1'b0},
        '{32'h7FFF_FFFD,   1'b0, 1'b0},
        '{32'h5555_5555,   1'b0, 1'b0},
        '{32'hAAAA_AAAB,   1'b1, 1'b0},
        '{32'd65535,       1'b0, 1'b0},
        '{32'd196563,      1'b0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    tdp_in_if  in_ch ();
    tdp_out_if out_ch ();

    trial_division_prime_test u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_owed_answer owed_answers [$];
    int unsigned  cycle_count    = 0;
    int           mismatch_count = 0;
    int           answers_seen   = 0;
    int           primes_seen    = 0;
    int           random_sent    = 0;

    // Answer by trial division over the low VALUE_WIDTH bits of the candidate.
    function automatic bit trial_divide_prime(logic [CANDIDATE_WIDTH-1:0] c);
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] sign;
        logic [63:0] d;
        mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
        v    = 64'(c) & mask;
        sign = 64'd1 << (VALUE_WIDTH - 1);
        if ((v & sign) != 0) return 1'b0;
        if (v <= 64'd1) return 1'b0;
        if (v == 64'd2) return 1'b1;
        if (v[0] == 1'b0) return 1'b0;
        for (d = 64'd3; d <= v / d; d = d + 64'd2) begin
            if (v % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Random candidates: mostly small odd values that run the divisor loop, with
    // negatives, evens and large values that have a small factor mixed in.
    function automatic logic [CANDIDATE_WIDTH-1:0] draw_candidate();
        logic [31:0] r;
        logic [31:0] p;
        logic [31:0] q;
        case ($urandom_range(9, 0))
            0, 1: begin
                r = $urandom_range(2047, 0);
            end
            2: begin
                p = 2 * $urandom_range(22, 1) + 1;
                q = 2 * $urandom_range(22, 1) + 1;
                r = p * q;
            end
            3: begin
                // Negative, or positive and even: both answered at once.
                r = $urandom;
                if (!r[31]) r[0] = 1'b0;
            end
            4: begin
                // Large odd multiple of three: found at the first divisor.
                r = $urandom_range(32'h7FFF_FFF0, 32'h0000_1000);
                r = r - (r % 3);
                if (!r[0]) r = r + 3;
            end
            default: begin
                r = 2 * $urandom_range(2047, 1) + 1;
            end
        endcase
        return r;
    endfunction

    // Offer one candidate after a gap and record the answer owed on transfer.
    task automatic offer_candidate(input logic [CANDIDATE_WIDTH-1:0] c, input int gap,
                                   input bit known, input bit flag);
        t_owed_answer entry;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.candidate <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        entry.candidate = c;
        entry.flag      = known ? flag : trial_divide_prime(c);
        owed_answers.push_back(entry);
        @(negedge i_clk);
    endtask

    // Hold the input quiet until every owed answer has come back.
    task automatic drain_answers();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (owed_answers.size() != 0);
    endtask

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off and a stretch with none.
    initial begin
        int           gap;
        t_owed_answer entry;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (answers_seen == N_DIRECTED + 20)
                gap = HOLD_CYCLES;
            else if (answers_seen >= N_DIRECTED + 50 && answers_seen < N_DIRECTED + 66)
                gap = 0;
            else
                gap = $urandom_range(8, 0);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            answers_seen++;
            if (owed_answers.size() == 0) begin
                $error("is_prime: result transferred with no candidate outstanding");
                mismatch_count++;
            end else begin
                entry = owed_answers.pop_front();
                if (out_ch.is_prime !== entry.flag) begin
                    $error("is_prime mismatch for candidate %0d: expected %0d, actual %0d",
                           $signed(entry.candidate), entry.flag, out_ch.is_prime);
                    mismatch_count++;
                end
                if (entry.flag) primes_seen++;
            end
            @(negedge i_clk);
        end
    end

    // Candidate side: reset, the directed table, then the random part.
    initial begin
        int gap;
        in_ch.valid     = 1'b0;
        in_ch.candidate = '0;
        i_rst_n         = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_candidate(directed_rows[i].candidate, $urandom_range(8, 0),
                            directed_rows[i].known, directed_rows[i].flag);
        end
        drain_answers();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Back-to-back offers while the result side holds off, and again in
            // the stretch where neither side idles.
            if ((n >= 18 && n < 45) || (n >= 48 && n < 68))
                gap = 0;
            else
                gap = $urandom_range(8, 0);
            if (n == 75) drain_answers();
            offer_candidate(draw_candidate(), gap, 1'b0, 1'b0);
            random_sent++;
        end
        in_ch.valid <= 1'b0;

        while (owed_answers.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Covered %0d directed and %0d random candidates, %0d answers, %0d prime.",
                 N_DIRECTED, random_sent, answers_seen, primes_seen);
        $display("Run took %0d cycles, with one long result stall and a full drain.",
                 cycle_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
